>>> design/cvpn_pkg.sv
// shared types and constants for the complex vector phase normalize unit
package cvpn_pkg;

    localparam int SUM_W   = 38;
    localparam int ROOT_W  = 19;
    localparam int DATA_W  = 16;
    localparam int ACC_W   = 34;
    localparam int NUM_W   = 32;
    localparam int DIV_W   = 20;
    localparam int QUO_W   = 17;
    localparam int REM_W   = 22;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_ENABLE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE_ENABLE = 8'd1;

    localparam logic signed [DATA_W-1:0] Q15_MAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] Q15_MIN = -16'sh8000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PMUL,
        ST_PRND,
        ST_SQ,
        ST_ROOT,
        ST_RD,
        ST_CHK,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

>>> design/complex_vector_phase_normalize_unit.sv
// top level of the complex vector phase normalize unit
//
// loads a complex vector one request at a time (start while busy is low). with
// phase_enable set, each coefficient is first multiplied by its phase in four
// passes of one shared 16x16 multiplier and rounded to q1.15, otherwise the
// coefficient is taken as is (squares go through the same multiplier). on the
// last element, or when the store fills, the norm is found by a bit-serial
// square root, then every stored element is read back and sent out on
// out_valid for one cycle each; the receiver cannot stall, so results simply
// appear. a normalized element goes through one restoring divider shared by
// both parts, an unscaled or zero-norm element skips it. busy stays high from
// an accepted request until the element has been squared and stored, or after
// a closing element until the last result of the vector has been strobed.
module complex_vector_phase_normalize_unit #(
    parameter int VECTOR_DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [cvpn_pkg::DATA_W-1:0]     coeff_re,
    input  logic signed [cvpn_pkg::DATA_W-1:0]     coeff_im,
    input  logic signed [cvpn_pkg::DATA_W-1:0]     phase_re,
    input  logic signed [cvpn_pkg::DATA_W-1:0]     phase_im,
    input  logic                                   last_element,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cvpn_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cvpn_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                   out_valid,
    output logic signed [cvpn_pkg::DATA_W-1:0]     out_re,
    output logic signed [cvpn_pkg::DATA_W-1:0]     out_im,
    output logic [cvpn_pkg::ROOT_W-1:0]            norm_value,
    output logic                                   zero_norm,
    output logic                                   last_result
);

    localparam int AW  = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int CW  = AW + 1;
    localparam logic [CW-1:0] LAST_SLOT = CW'(VECTOR_DEPTH - 1);

    // element store, re in low half, im in high half
    logic [2*cvpn_pkg::DATA_W-1:0] mem [VECTOR_DEPTH];
    logic [2*cvpn_pkg::DATA_W-1:0] rd_reg;

    cvpn_pkg::state_t state_reg, state_next;

    logic phase_en_reg, norm_en_reg;
    logic signed [cvpn_pkg::DATA_W-1:0] cr_reg, ci_reg, pr_reg, pi_reg;
    logic last_reg;
    logic [4:0] step_reg;
    logic signed [cvpn_pkg::ACC_W-1:0] acc_re_reg, acc_im_reg;
    logic [cvpn_pkg::SUM_W-1:0] sum_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] idx_reg;

    // square root
    logic [cvpn_pkg::SUM_W-1:0] x_reg;
    logic [cvpn_pkg::REM_W-1:0] rem_reg;
    logic [cvpn_pkg::ROOT_W-1:0] root_reg;

    // divider
    logic [cvpn_pkg::NUM_W-1:0] num_reg;
    logic [cvpn_pkg::DIV_W+cvpn_pkg::QUO_W-1:0] dsh_reg;
    logic [cvpn_pkg::QUO_W-1:0] quo_reg;
    logic ovf_reg, neg_reg, comp_reg;

    logic signed [cvpn_pkg::DATA_W-1:0] ore_reg, oim_reg;

    logic accept;
    logic closing;

    assign accept    = start && (state_reg == cvpn_pkg::ST_IDLE);
    assign busy      = (state_reg != cvpn_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign closing   = last_reg || (cnt_reg == LAST_SLOT);

    // shared multiplier, operands picked by the step counter
    logic signed [cvpn_pkg::DATA_W-1:0] mul_a, mul_b;
    logic signed [2*cvpn_pkg::DATA_W-1:0] prod;

    always_comb
    begin
        mul_a = cr_reg;
        mul_b = pr_reg;
        if (state_reg == cvpn_pkg::ST_PMUL)
        begin
            case (step_reg[1:0])
                2'd0:    begin mul_a = cr_reg; mul_b = pr_reg; end
                2'd1:    begin mul_a = ci_reg; mul_b = pi_reg; end
                2'd2:    begin mul_a = cr_reg; mul_b = pi_reg; end
                default: begin mul_a = ci_reg; mul_b = pr_reg; end
            endcase
        end
        else
        begin
            mul_a = step_reg[0] ? ci_reg : cr_reg;
            mul_b = mul_a;
        end
    end

    assign prod = mul_a * mul_b;

    // rounding of the phase products to q1.15 with saturation
    function automatic logic signed [cvpn_pkg::DATA_W-1:0] rnd_sat(
        input logic signed [cvpn_pkg::ACC_W-1:0] x);
        logic signed [cvpn_pkg::ACC_W-1:0] t;
        logic signed [cvpn_pkg::ACC_W-1:0] q;
        t = x + cvpn_pkg::ACC_W'(16384);
        q = t >>> 15;
        if (q > cvpn_pkg::ACC_W'(signed'(cvpn_pkg::Q15_MAX)))
            rnd_sat = cvpn_pkg::Q15_MAX;
        else if (q < cvpn_pkg::ACC_W'(signed'(cvpn_pkg::Q15_MIN)))
            rnd_sat = cvpn_pkg::Q15_MIN;
        else
            rnd_sat = q[cvpn_pkg::DATA_W-1:0];
    endfunction

    // square root step
    logic [cvpn_pkg::REM_W-1:0] rem_sh, trial;
    assign rem_sh = {rem_reg[cvpn_pkg::REM_W-3:0], x_reg[cvpn_pkg::SUM_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // divider setup for the element part being worked on
    logic signed [cvpn_pkg::DATA_W-1:0] div_src;
    logic [cvpn_pkg::DATA_W:0] div_mag;
    logic [cvpn_pkg::NUM_W-1:0] div_num;
    logic [cvpn_pkg::DIV_W-1:0] div_den;
    logic [cvpn_pkg::DIV_W+cvpn_pkg::QUO_W:0] div_lim;

    always_comb
    begin
        div_src = comp_reg ? oim_reg : ore_reg;
        if (state_reg == cvpn_pkg::ST_CHK)
            div_src = signed'(rd_reg[cvpn_pkg::DATA_W-1:0]);
        div_mag = div_src[cvpn_pkg::DATA_W-1] ?
                  (cvpn_pkg::DATA_W+1)'(-(cvpn_pkg::DATA_W+1)'(signed'(div_src))) :
                  (cvpn_pkg::DATA_W+1)'(div_src);
        div_num = (cvpn_pkg::NUM_W'(div_mag) << 16) + cvpn_pkg::NUM_W'(root_reg);
        div_den = {root_reg, 1'b0};
        div_lim = (cvpn_pkg::DIV_W+cvpn_pkg::QUO_W+1)'(div_den) << cvpn_pkg::QUO_W;
    end

    logic [cvpn_pkg::DIV_W+cvpn_pkg::QUO_W-1:0] num_ext;
    logic div_ge;
    assign num_ext = (cvpn_pkg::DIV_W+cvpn_pkg::QUO_W)'(num_reg);
    assign div_ge  = (num_ext >= dsh_reg);

    // signed saturated quotient from the finished divide
    logic [cvpn_pkg::QUO_W-1:0] quo_fin;
    logic signed [cvpn_pkg::DATA_W-1:0] div_res;

    always_comb
    begin
        quo_fin = {quo_reg[cvpn_pkg::QUO_W-2:0], div_ge};
        if (neg_reg)
        begin
            if (ovf_reg || quo_fin > cvpn_pkg::QUO_W'(32768))
                div_res = cvpn_pkg::Q15_MIN;
            else
                div_res = cvpn_pkg::DATA_W'(-quo_fin);
        end
        else
        begin
            if (ovf_reg || quo_fin > cvpn_pkg::QUO_W'(32767))
                div_res = cvpn_pkg::Q15_MAX;
            else
                div_res = signed'(quo_fin[cvpn_pkg::DATA_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cvpn_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cvpn_pkg::ST_IDLE:
                if (accept)
                    state_next = phase_en_reg ? cvpn_pkg::ST_PMUL : cvpn_pkg::ST_SQ;
            cvpn_pkg::ST_PMUL:
                if (step_reg[1:0] == 2'd3)
                    state_next = cvpn_pkg::ST_PRND;
            cvpn_pkg::ST_PRND:
                state_next = cvpn_pkg::ST_SQ;
            cvpn_pkg::ST_SQ:
                if (step_reg[0])
                    state_next = closing ? cvpn_pkg::ST_ROOT : cvpn_pkg::ST_IDLE;
            cvpn_pkg::ST_ROOT:
                if (step_reg == 5'd18)
                    state_next = cvpn_pkg::ST_RD;
            cvpn_pkg::ST_RD:
                state_next = cvpn_pkg::ST_CHK;
            cvpn_pkg::ST_CHK:
                state_next = (root_reg == '0 || !norm_en_reg) ?
                             cvpn_pkg::ST_EMIT : cvpn_pkg::ST_DIV;
            cvpn_pkg::ST_DIV:
                if (step_reg == 5'd16 && comp_reg)
                    state_next = cvpn_pkg::ST_EMIT;
            cvpn_pkg::ST_EMIT:
                state_next = (idx_reg + 1'b1 == cnt_reg) ? cvpn_pkg::ST_IDLE :
                             cvpn_pkg::ST_RD;
            default:
                state_next = cvpn_pkg::ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_en_reg <= 1'b0;
            norm_en_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == cvpn_pkg::REG_PHASE_ENABLE)
                phase_en_reg <= cfg_data[0];
            else if (cfg_index == cvpn_pkg::REG_NORMALIZE_ENABLE)
                norm_en_reg <= cfg_data[0];
        end
    end

    // control counters and accumulated state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
            comp_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                cvpn_pkg::ST_IDLE:
                    step_reg <= '0;
                cvpn_pkg::ST_PMUL:
                    step_reg <= (step_reg[1:0] == 2'd3) ? 5'd0 : step_reg + 5'd1;
                cvpn_pkg::ST_SQ:
                begin
                    if (step_reg[0])
                    begin
                        step_reg <= '0;
                        idx_reg  <= '0;
                        if (closing)
                            sum_reg <= '0;
                        else
                            sum_reg <= sum_reg + cvpn_pkg::SUM_W'(unsigned'(prod));
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        sum_reg  <= sum_reg + cvpn_pkg::SUM_W'(unsigned'(prod));
                        step_reg <= 5'd1;
                    end
                end
                cvpn_pkg::ST_ROOT:
                    step_reg <= (step_reg == 5'd18) ? 5'd0 : step_reg + 5'd1;
                cvpn_pkg::ST_CHK:
                begin
                    step_reg <= '0;
                    comp_reg <= 1'b0;
                end
                cvpn_pkg::ST_DIV:
                    if (step_reg == 5'd16)
                    begin
                        step_reg <= '0;
                        comp_reg <= 1'b1;
                    end
                    else
                        step_reg <= step_reg + 5'd1;
                cvpn_pkg::ST_EMIT:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == cnt_reg)
                        cnt_reg <= '0;
                end
                default:
                    step_reg <= step_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            cvpn_pkg::ST_IDLE:
                if (accept)
                begin
                    cr_reg   <= coeff_re;
                    ci_reg   <= coeff_im;
                    pr_reg   <= phase_re;
                    pi_reg   <= phase_im;
                    last_reg <= last_element;
                end
            cvpn_pkg::ST_PMUL:
                case (step_reg[1:0])
                    2'd0:    acc_re_reg <= cvpn_pkg::ACC_W'(prod);
                    2'd1:    acc_re_reg <= acc_re_reg - cvpn_pkg::ACC_W'(prod);
                    2'd2:    acc_im_reg <= cvpn_pkg::ACC_W'(prod);
                    default: acc_im_reg <= acc_im_reg + cvpn_pkg::ACC_W'(prod);
                endcase
            cvpn_pkg::ST_PRND:
            begin
                cr_reg <= rnd_sat(acc_re_reg);
                ci_reg <= rnd_sat(acc_im_reg);
            end
            cvpn_pkg::ST_SQ:
                if (step_reg[0])
                begin
                    // full sum goes to the root unit, mask to its width
                    x_reg    <= sum_reg + cvpn_pkg::SUM_W'(unsigned'(prod));
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            cvpn_pkg::ST_ROOT:
            begin
                x_reg <= x_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[cvpn_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[cvpn_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            cvpn_pkg::ST_CHK:
            begin
                if (root_reg == '0)
                begin
                    ore_reg <= '0;
                    oim_reg <= '0;
                end
                else
                begin
                    ore_reg <= signed'(rd_reg[cvpn_pkg::DATA_W-1:0]);
                    oim_reg <= signed'(rd_reg[2*cvpn_pkg::DATA_W-1:cvpn_pkg::DATA_W]);
                end
                num_reg <= div_num;
                dsh_reg <= (cvpn_pkg::DIV_W+cvpn_pkg::QUO_W)'(div_den) << 16;
                ovf_reg <= ((cvpn_pkg::DIV_W+cvpn_pkg::QUO_W+1)'(div_num) >= div_lim);
                neg_reg <= div_src[cvpn_pkg::DATA_W-1];
                quo_reg <= '0;
            end
            cvpn_pkg::ST_DIV:
            begin
                if (step_reg == 5'd16 && !comp_reg)
                begin
                    ore_reg <= div_res;
                    // set up the imaginary part
                    num_reg <= (cvpn_pkg::NUM_W'(oim_reg[cvpn_pkg::DATA_W-1] ?
                               (cvpn_pkg::DATA_W+1)'(-(cvpn_pkg::DATA_W+1)'(oim_reg)) :
                               (cvpn_pkg::DATA_W+1)'(oim_reg)) << 16)
                               + cvpn_pkg::NUM_W'(root_reg);
                    dsh_reg <= (cvpn_pkg::DIV_W+cvpn_pkg::QUO_W)'(div_den) << 16;
                    ovf_reg <= ((cvpn_pkg::DIV_W+cvpn_pkg::QUO_W+1)'(
                               (cvpn_pkg::NUM_W'(oim_reg[cvpn_pkg::DATA_W-1] ?
                               (cvpn_pkg::DATA_W+1)'(-(cvpn_pkg::DATA_W+1)'(oim_reg)) :
                               (cvpn_pkg::DATA_W+1)'(oim_reg)) << 16)
                               + cvpn_pkg::NUM_W'(root_reg)) >= div_lim);
                    neg_reg <= oim_reg[cvpn_pkg::DATA_W-1];
                    quo_reg <= '0;
                end
                else
                begin
                    quo_reg <= quo_fin;
                    dsh_reg <= dsh_reg >> 1;
                    if (div_ge)
                        num_reg <= num_reg - cvpn_pkg::NUM_W'(dsh_reg);
                    if (step_reg == 5'd16)
                        oim_reg <= div_res;
                end
            end
            default:
                cr_reg <= cr_reg;
        endcase
    end

    // element store, written on the first square pass, read back for output
    always_ff @(posedge clk)
    begin
        if (state_reg == cvpn_pkg::ST_SQ && !step_reg[0])
            mem[cnt_reg[AW-1:0]] <= {ci_reg, cr_reg};
        rd_reg <= mem[idx_reg[AW-1:0]];
    end

    assign out_valid   = (state_reg == cvpn_pkg::ST_EMIT);
    assign out_re      = ore_reg;
    assign out_im      = oim_reg;
    assign norm_value  = root_reg;
    assign zero_norm   = (root_reg == '0);
    assign last_result = (idx_reg + 1'b1 == cnt_reg);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted request did not raise busy");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_result) |=> !busy)
        else $error("block still busy after last result");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_norm) |-> (out_re == '0 && out_im == '0))
        else $error("zero norm result is not zero");

endmodule

>>> test/complex_vector_phase_normalize_unit_test.sv
// self-checking testbench for the complex vector phase normalize unit
module complex_vector_phase_normalize_unit_test;

    localparam int DEPTH = 64;
    localparam int HANG_LIMIT = 20000;

    typedef struct packed {
        logic signed [cvpn_pkg::DATA_W-1:0] re;
        logic signed [cvpn_pkg::DATA_W-1:0] im;
        logic [cvpn_pkg::ROOT_W-1:0]        nrm;
        logic                               zflag;
        logic                               lastf;
    } vec_result_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [cvpn_pkg::DATA_W-1:0] coeff_re;
    logic signed [cvpn_pkg::DATA_W-1:0] coeff_im;
    logic signed [cvpn_pkg::DATA_W-1:0] phase_re;
    logic signed [cvpn_pkg::DATA_W-1:0] phase_im;
    logic last_element;
    logic cfg_valid;
    logic cfg_ready;
    logic [cvpn_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cvpn_pkg::CFG_DATA_W-1:0] cfg_data;
    logic out_valid;
    logic signed [cvpn_pkg::DATA_W-1:0] out_re;
    logic signed [cvpn_pkg::DATA_W-1:0] out_im;
    logic [cvpn_pkg::ROOT_W-1:0] norm_value;
    logic zero_norm;
    logic last_result;

    // predictor copy of the block state and registers
    logic [31:0] model_store [DEPTH];
    logic [cvpn_pkg::SUM_W-1:0] model_sum;
    int model_count;
    logic model_phase_en;
    logic model_norm_en;

    vec_result_t pending_results [$];
    int mismatches;
    int idle_cycles;
    bit quiet_mode;

    complex_vector_phase_normalize_unit #(.VECTOR_DEPTH(DEPTH)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coeff_re(coeff_re), .coeff_im(coeff_im),
        .phase_re(phase_re), .phase_im(phase_im),
        .last_element(last_element),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_re(out_re), .out_im(out_im),
        .norm_value(norm_value), .zero_norm(zero_norm), .last_result(last_result)
    );

    // free running clock, period 8
    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic signed [15:0] sat_q15(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return v[15:0];
    endfunction

    // q2.30 to q1.15, ties toward plus infinity (arithmetic shift is floor)
    function automatic logic signed [15:0] round_q30(longint x);
        return sat_q15((x + 16384) >>> 15);
    endfunction

    function automatic longint int_sqrt(longint x);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // divide by norm, ties away from zero, then saturate
    function automatic logic signed [15:0] div_by_norm(longint e, longint n);
        longint mag;
        longint q;
        mag = (e < 0) ? -e : e;
        q = ((mag << 16) + n) / (2 * n);
        return sat_q15((e < 0) ? -q : q);
    endfunction

    // fold one element into the predictor, queue the vector's results on close
    task automatic predict_element(logic signed [15:0] cr, logic signed [15:0] ci,
                                   logic signed [15:0] pr, logic signed [15:0] pim,
                                   logic lastf);
        longint a;
        longint b;
        longint er;
        longint ei;
        longint nrm;
        logic signed [15:0] sr;
        logic signed [15:0] si;
        vec_result_t res;
        sr = cr;
        si = ci;
        if (model_phase_en)
        begin
            a = longint'(cr) * pr - longint'(ci) * pim;
            b = longint'(cr) * pim + longint'(ci) * pr;
            sr = round_q30(a);
            si = round_q30(b);
        end
        model_store[model_count] = {si, sr};
        model_sum = model_sum + cvpn_pkg::SUM_W'(longint'(sr) * sr + longint'(si) * si);
        model_count++;
        if (!lastf && model_count < DEPTH) return;
        nrm = int_sqrt(longint'(model_sum));
        for (int k = 0; k < model_count; k++)
        begin
            er = $signed(model_store[k][15:0]);
            ei = $signed(model_store[k][31:16]);
            if (nrm == 0)
            begin
                res.re = '0;
                res.im = '0;
            end
            else if (model_norm_en)
            begin
                res.re = div_by_norm(er, nrm);
                res.im = div_by_norm(ei, nrm);
            end
            else
            begin
                res.re = er[15:0];
                res.im = ei[15:0];
            end
            res.nrm = nrm[cvpn_pkg::ROOT_W-1:0];
            res.zflag = (nrm == 0);
            res.lastf = (k + 1 == model_count);
            pending_results.push_back(res);
        end
        model_sum = '0;
        model_count = 0;
    endtask

    // random idle gaps except in quiet stretches, start low while idling
    task automatic maybe_idle();
        while (!quiet_mode && $urandom_range(99) < 14)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    // send one element request and predict at acceptance, start stays up
    task automatic send_element(logic signed [15:0] cr, logic signed [15:0] ci,
                                logic signed [15:0] pr, logic signed [15:0] pim,
                                logic lastf);
        maybe_idle();
        start <= 1'b1;
        coeff_re <= cr;
        coeff_im <= ci;
        phase_re <= pr;
        phase_im <= pim;
        last_element <= lastf;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_element(cr, ci, pr, pim, lastf);
        @(negedge clk);
    endtask

    // wait until all queued results have arrived plus some slack
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // register write once the block is idle
    task automatic write_reg(logic [cvpn_pkg::CFG_IDX_W-1:0] idx,
                             logic [cvpn_pkg::CFG_DATA_W-1:0] val);
        start <= 1'b0;
        while (busy) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == cvpn_pkg::REG_PHASE_ENABLE) model_phase_en = val[0];
        else if (idx == cvpn_pkg::REG_NORMALIZE_ENABLE) model_norm_en = val[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_q15();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'($urandom_range(64)) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // result checker: compare each strobe with the oldest expectation
    always @(posedge clk)
    begin
        vec_result_t want;
        if (rst_n && out_valid)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result re=%0d im=%0d", out_re, out_im);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.re !== out_re || want.im !== out_im || want.nrm !== norm_value
                    || want.zflag !== zero_norm || want.lastf !== last_result)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp re=%0d im=%0d n=%0d z=%0b l=%0b",
                                  " got re=%0d im=%0d n=%0d z=%0b l=%0b"},
                                 want.re, want.im, want.nrm, want.zflag, want.lastf,
                                 out_re, out_im, norm_value, zero_norm, last_result);
                end
            end
        end
    end

    // watchdog on cycles with no accepted request, write or result
    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > HANG_LIMIT)
        begin
            $display("FAIL complex_vector_phase_normalize_unit");
            $finish;
        end
    end

    task automatic test_directed_extremes();
        // extremes of coefficient and phase, phase multiply off
        send_element(16'sh7fff, -16'sh8000, 16'sh0, 16'sh0, 1'b0);
        send_element(-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, 1'b0);
        send_element(16'sh1, -16'sh1, 16'sh0, 16'sh0, 1'b1);
        // zero vector gives zero norm
        send_element(16'sh0, 16'sh0, 16'sh7fff, 16'sh7fff, 1'b0);
        send_element(16'sh0, 16'sh0, -16'sh8000, 16'sh1, 1'b1);
        // single tiny element: division saturates
        send_element(16'sh1, 16'sh0, 16'sh0, 16'sh0, 1'b1);
        drain();
    endtask

    task automatic test_phase_multiply();
        write_reg(cvpn_pkg::REG_PHASE_ENABLE, 8'hff);
        // -1 * -1 saturates, rounding ties, conjugate style phases
        send_element(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 1'b0);
        send_element(16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, 1'b0);
        send_element(16'sh4000, -16'sh4000, 16'sh1, 16'sh1, 1'b0);
        send_element(-16'sh1, 16'sh1, 16'sh4000, 16'sh4000, 1'b1);
        // products that round to zero
        send_element(16'sh1, 16'sh1, 16'sh1, -16'sh1, 1'b1);
        drain();
    endtask

    task automatic test_unscaled();
        write_reg(cvpn_pkg::REG_NORMALIZE_ENABLE, 8'h00);
        write_reg(cvpn_pkg::REG_PHASE_ENABLE, 8'h00);
        send_element(16'sh7fff, -16'sh8000, 16'sh0, 16'sh0, 1'b0);
        send_element(16'sh1234, 16'sh0, 16'sh0, 16'sh0, 1'b1);
        send_element(16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b1);
        // index beyond the registers is ignored
        write_reg(8'hfe, 8'h01);
        drain();
    endtask

    task automatic test_store_full();
        // store fills without last_element and closes the vector
        write_reg(cvpn_pkg::REG_NORMALIZE_ENABLE, 8'h01);
        for (int i = 0; i < DEPTH; i++)
            send_element(rand_q15(), rand_q15(), rand_q15(), rand_q15(), 1'b0);
        drain();
    endtask

    task automatic test_random_vectors();
        int sent;
        int len;
        sent = 0;
        while (sent < 350)
        begin
            write_reg(cvpn_pkg::REG_PHASE_ENABLE, 8'($urandom));
            write_reg(cvpn_pkg::REG_NORMALIZE_ENABLE, 8'($urandom));
            quiet_mode = (sent > 150 && sent < 220);
            // mostly short vectors, rarely long ones
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(8, 1);
            for (int i = 0; i < len; i++)
            begin
                send_element(rand_q15(), rand_q15(), rand_q15(), rand_q15(),
                             (i == len - 1) ? 1'b1 : 1'b0);
                sent++;
            end
            if ($urandom_range(3) == 0)
                drain();
        end
        quiet_mode = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        coeff_re = '0;
        coeff_im = '0;
        phase_re = '0;
        phase_im = '0;
        last_element = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        quiet_mode = 1'b0;
        model_sum = '0;
        model_count = 0;
        model_phase_en = 1'b0;
        model_norm_en = 1'b1;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_extremes();
        test_phase_multiply();
        test_unscaled();
        test_store_full();
        test_random_vectors();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS complex_vector_phase_normalize_unit");
        else
            $display("FAIL complex_vector_phase_normalize_unit");
        $finish;
    end

endmodule
